/* rtl/pfdm_pkg.sv */
// Shared constants, types and controller codes of the PWM frequency and duty meter.
package pfdm_pkg;

  localparam int unsigned STAMP_BITS  = 32;
  localparam int unsigned HIGH_BITS   = STAMP_BITS;
  localparam int unsigned LOW_BITS    = STAMP_BITS - 1;
  localparam int unsigned PERIOD_BITS = STAMP_BITS;
  localparam int unsigned CLOCK_BITS  = 28;
  localparam int unsigned DUTY_BITS   = 14;
  localparam int unsigned PROD_BITS   = HIGH_BITS + DUTY_BITS;
  localparam int unsigned FREQ_STEPS  = CLOCK_BITS;
  localparam int unsigned DUTY_STEPS  = DUTY_BITS;
  localparam int unsigned CNT_BITS    = $clog2(FREQ_STEPS);
  localparam int unsigned OUT_FIELD_BITS = CLOCK_BITS + DUTY_BITS + 32 + 31;
  localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [CLOCK_BITS-1:0] ClockReset = CLOCK_BITS'(80000000);
  localparam logic [DUTY_BITS-1:0]  DutyScale  = DUTY_BITS'(10000);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIMES,
    S_PREP,
    S_FREQ_RUN,
    S_DUTY_LOAD,
    S_DUTY_RUN,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // store the accepted timestamp
    logic update;     // derive high or low time from the stamps
    logic prep;       // register period and scaled high time
    logic load_freq;  // start the frequency division
    logic load_duty;  // save the frequency quotient, start the duty division
    logic step;       // one divider iteration
    logic emit;       // load the output register
  } cmd_t;

  typedef struct packed {
    logic none;       // both times are zero
  } status_t;

endpackage

/* rtl/pwm_frequency_duty_meter.sv */
// Top level of the PWM frequency and duty meter.
// Each input transfer carries one captured edge (timer stamp and polarity) and yields exactly
// one result transfer with frequency, duty in hundredths of a percent, the high and low times
// in ticks and a no-signal flag. The next edge is taken only once this result has been loaded into
// the output register; when both times are zero the divisions are skipped. Both quotients come
// from the shared one-bit-per-cycle divider: 28 steps for the frequency quotient and 14 steps
// for the duty quotient. A finished result sits in an output register, so the next edge is
// taken while it waits; the block holds in its last step only when a second result is ready
// before the first has been taken. The timer clock register may be written at any time the
// block is idle and takes effect for the next edge.
module pwm_frequency_duty_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pfdm_pkg::CLOCK_BITS-1:0]     cfg_data_i,     // timer_clock_hz
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,   // edge_time
  input  logic                                s_axis_tuser,   // edge_rising
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // frequency_hz [27:0], duty_hundredths [41:28], high_ticks [73:42], low_ticks [104:74]
  output logic [pfdm_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  output logic                                m_axis_tuser    // no_signal
);

  pfdm_pkg::cmd_t    cmd;
  pfdm_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pfdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pfdm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .edge_time_i   (s_axis_tdata),
    .edge_rising_i (s_axis_tuser),
    .out_data_o    (m_axis_tdata),
    .out_none_o    (m_axis_tuser)
  );

endmodule

/* rtl/pfdm_divider.sv */
// Restoring divider that produces one quotient bit per step.
module pfdm_divider (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                step_i,
  input  logic [pfdm_pkg::PERIOD_BITS-1:0]    rem_init_i,
  input  logic [pfdm_pkg::CLOCK_BITS-1:0]     bits_init_i,
  input  logic [pfdm_pkg::PERIOD_BITS-1:0]    divisor_i,
  output logic [pfdm_pkg::CLOCK_BITS-1:0]     quotient_o
);

  logic [pfdm_pkg::PERIOD_BITS-1:0] rem_q, rem_d;
  logic [pfdm_pkg::CLOCK_BITS-1:0]  bits_q, bits_d;
  logic [pfdm_pkg::PERIOD_BITS:0]   trial;
  logic [pfdm_pkg::PERIOD_BITS:0]   diff;
  logic                             qbit;

  // Numerator bits leave at the top of the shift register while quotient
  // bits enter at the bottom.
  always_comb begin
    trial  = {rem_q, bits_q[pfdm_pkg::CLOCK_BITS-1]};
    diff   = trial - {1'b0, divisor_i};
    qbit   = (trial >= {1'b0, divisor_i});
    rem_d  = rem_q;
    bits_d = bits_q;
    if (load_i) begin
      rem_d  = rem_init_i;
      bits_d = bits_init_i;
    end else if (step_i) begin
      rem_d  = qbit ? diff[pfdm_pkg::PERIOD_BITS-1:0] : trial[pfdm_pkg::PERIOD_BITS-1:0];
      bits_d = {bits_q[pfdm_pkg::CLOCK_BITS-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
  end

  assign quotient_o = bits_q;

endmodule

/* rtl/pfdm_datapath.sv */
// Datapath: clock register, stamps, high and low times, divisions and result register.
module pfdm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfdm_pkg::cmd_t                      cmd_i,
  output pfdm_pkg::status_t                   status_o,
  input  logic                                cfg_we_i,
  input  logic [pfdm_pkg::CLOCK_BITS-1:0]     cfg_data_i,
  input  logic [31:0]                         edge_time_i,
  input  logic                                edge_rising_i,
  output logic [pfdm_pkg::OUT_DATA_BITS-1:0]  out_data_o,
  output logic                                out_none_o
);

  logic [pfdm_pkg::CLOCK_BITS-1:0]  clock_q;
  logic [pfdm_pkg::STAMP_BITS-1:0]  rise_q, fall_q;
  logic [pfdm_pkg::HIGH_BITS-1:0]   high_q;
  logic [pfdm_pkg::LOW_BITS-1:0]    low_q;
  logic [pfdm_pkg::PERIOD_BITS-1:0] period_q;
  logic [pfdm_pkg::PROD_BITS-1:0]   prod_q;
  logic [pfdm_pkg::CLOCK_BITS-1:0]  freq_q;
  logic [pfdm_pkg::STAMP_BITS-1:0]  diff;
  logic                             none;

  logic [pfdm_pkg::PERIOD_BITS-1:0] rem_init;
  logic [pfdm_pkg::CLOCK_BITS-1:0]  bits_init;
  logic [pfdm_pkg::CLOCK_BITS-1:0]  quotient;

  logic [pfdm_pkg::CLOCK_BITS-1:0]  res_freq;
  logic [pfdm_pkg::DUTY_BITS-1:0]   res_duty;

  assign diff = rise_q - fall_q;
  assign none = (high_q == '0) && (low_q == '0);
  assign status_o.none = none;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= pfdm_pkg::ClockReset;
      rise_q  <= '0;
      fall_q  <= '0;
      high_q  <= '0;
      low_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        clock_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        if (edge_rising_i) begin
          rise_q <= edge_time_i[pfdm_pkg::STAMP_BITS-1:0];
        end else begin
          fall_q <= edge_time_i[pfdm_pkg::STAMP_BITS-1:0];
        end
      end
      if (cmd_i.update) begin
        // A positive signed difference is the low time; otherwise its
        // magnitude is the high time, which also covers a zero difference.
        if ((diff != '0) && !diff[pfdm_pkg::STAMP_BITS-1]) begin
          low_q <= diff[pfdm_pkg::LOW_BITS-1:0];
        end else begin
          high_q <= '0 - diff;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      period_q <= pfdm_pkg::PERIOD_BITS'(high_q) + pfdm_pkg::PERIOD_BITS'(low_q);
      prod_q   <= pfdm_pkg::PROD_BITS'(high_q) * pfdm_pkg::PROD_BITS'(pfdm_pkg::DutyScale);
    end
    if (cmd_i.load_duty) begin
      freq_q <= quotient;
    end
  end

  // The duty quotient stays below 2^DUTY_STEPS, so its partial remainder
  // starts at the upper product bits and only the low bits are shifted in.
  always_comb begin
    if (cmd_i.load_duty) begin
      rem_init  = prod_q[pfdm_pkg::PROD_BITS-1:pfdm_pkg::DUTY_STEPS];
      bits_init = {prod_q[pfdm_pkg::DUTY_STEPS-1:0],
                   {(pfdm_pkg::CLOCK_BITS - pfdm_pkg::DUTY_STEPS){1'b0}}};
    end else begin
      rem_init  = '0;
      bits_init = clock_q;
    end
  end

  pfdm_divider u_divider (
    .clk_i       (clk_i),
    .load_i      (cmd_i.load_freq | cmd_i.load_duty),
    .step_i      (cmd_i.step),
    .rem_init_i  (rem_init),
    .bits_init_i (bits_init),
    .divisor_i   (period_q),
    .quotient_o  (quotient)
  );

  assign res_freq = none ? '0 : freq_q;
  assign res_duty = none ? '0 : quotient[pfdm_pkg::DUTY_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_o <= pfdm_pkg::OUT_DATA_BITS'({31'(low_q), 32'(high_q), res_duty, res_freq});
      out_none_o <= none;
    end
  end

endmodule

/* rtl/pfdm_ctrl.sv */
// Controller state machine that sequences one edge through the datapath.
module pfdm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pfdm_pkg::status_t   status_i,
  output pfdm_pkg::cmd_t      cmd_o
);

  pfdm_pkg::state_e               state_q, state_d;
  logic [pfdm_pkg::CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfdm_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      pfdm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pfdm_pkg::S_TIMES;
        end
      end
      pfdm_pkg::S_TIMES: begin
        cmd_o.update = 1'b1;
        state_d      = pfdm_pkg::S_PREP;
      end
      pfdm_pkg::S_PREP: begin
        if (status_i.none) begin
          state_d = pfdm_pkg::S_EMIT;
        end else begin
          cmd_o.prep      = 1'b1;
          cmd_o.load_freq = 1'b1;
          cnt_d           = pfdm_pkg::CNT_BITS'(pfdm_pkg::FREQ_STEPS - 1);
          state_d         = pfdm_pkg::S_FREQ_RUN;
        end
      end
      pfdm_pkg::S_FREQ_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = pfdm_pkg::S_DUTY_LOAD;
        end
      end
      pfdm_pkg::S_DUTY_LOAD: begin
        cmd_o.load_duty = 1'b1;
        cnt_d           = pfdm_pkg::CNT_BITS'(pfdm_pkg::DUTY_STEPS - 1);
        state_d         = pfdm_pkg::S_DUTY_RUN;
      end
      pfdm_pkg::S_DUTY_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = pfdm_pkg::S_EMIT;
        end
      end
      pfdm_pkg::S_EMIT: begin
        // Wait here until the previous result has left the output register.
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pfdm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pfdm_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
